// ===== rtl/core/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// Field widths, operation codes, span slot limits and the snapshot that
// passes from the circle walk to the span emitter.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // coordinate and term widths
    localparam int COORD_BITS = 12;
    localparam int IN_COORD_W = 12;
    localparam int RAD_W      = 11;
    localparam int WALK_W     = 13;
    localparam int DEC_W      = 16;
    localparam int CHG_W      = 14;
    localparam int SPAN_W     = 14;
    localparam int COLOR_W    = 32;
    localparam int IDX_W      = 3;

    // slot index of the last span of one iteration
    localparam logic [IDX_W-1:0] IDX_OUTLINE_LAST = 3'd7;
    localparam logic [IDX_W-1:0] IDX_FILL_LAST    = 3'd3;

    // operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // one iteration worth of span work, handed to the emitter
    typedef struct packed {
        logic                     fill;
        logic                     last;
        logic [COORD_BITS-1:0]    cx;
        logic [COORD_BITS-1:0]    cy;
        logic signed [WALK_W-1:0] x;
        logic signed [WALK_W-1:0] y;
        logic [COLOR_W-1:0]       color;
    } t_snap;

endpackage

// ===== rtl/core/mcr_if.sv =====
// ----------------------------------------------------------------------------
// mcr_if: channel interfaces of the midpoint circle rasterizer
// Valid/ready channels for command words in and span words out.
// ----------------------------------------------------------------------------
interface mcr_in_if
    import mcr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [IN_COORD_W-1:0] center_x;
    logic [IN_COORD_W-1:0] center_y;
    logic [RAD_W-1:0]      radius;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  filled;

    modport source (
        output valid, op, center_x, center_y, radius, pixel_color, filled,
        input  ready
    );
    modport sink (
        input  valid, op, center_x, center_y, radius, pixel_color, filled,
        output ready
    );
endinterface

interface mcr_out_if
    import mcr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [SPAN_W-1:0] span_row;
    logic signed [SPAN_W-1:0] span_first;
    logic signed [SPAN_W-1:0] span_final;
    logic [COLOR_W-1:0]       span_color;
    logic                     last;

    modport source (
        output valid, span_row, span_first, span_final, span_color, last,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_first, span_final, span_color, last,
        output ready
    );
endinterface

// ===== rtl/core/midpoint_circle_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit: midpoint circle span generator
// Walks the integer midpoint circle one iteration per start word or step on
// a running circle, sending eight outline pixels or four filled spans each.
// ----------------------------------------------------------------------------
//  channel  dir  words                                   handshake
//  i_in     in   op, center_x/y, radius, pixel_color,    valid/ready
//                filled
//  o_out    out  span_row, span_first, span_final,       valid/ready
//                span_color, last
//
//  A command word is accepted in the valid/ready handshake; its circle
//  iteration is computed on acceptance and its spans leave one word per
//  cycle unless o_out stalls: eight spans (outline) or four (filled). A
//  step while idle is accepted and produces no spans. The next word is
//  taken in the cycle the last span of the previous one moves to the
//  output register. Synchronous active-low reset; no clearing pass. A
//  stall on o_out holds the output word and backs up into i_in.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
    import mcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_out_if.source o_out
);

    // circle walk state
    logic                     r_busy;
    logic                     r_fill;
    logic [COORD_BITS-1:0]    r_cx;
    logic [COORD_BITS-1:0]    r_cy;
    logic signed [WALK_W-1:0] r_x;
    logic signed [WALK_W-1:0] r_y;
    logic signed [DEC_W-1:0]  r_dec;
    logic signed [CHG_W-1:0]  r_xc;
    logic signed [CHG_W-1:0]  r_yc;
    logic [COLOR_W-1:0]       r_color;

    logic                     n_busy;
    logic                     n_fill;
    logic [COORD_BITS-1:0]    n_cx;
    logic [COORD_BITS-1:0]    n_cy;
    logic signed [WALK_W-1:0] n_x;
    logic signed [WALK_W-1:0] n_y;
    logic signed [DEC_W-1:0]  n_dec;
    logic signed [CHG_W-1:0]  n_xc;
    logic signed [CHG_W-1:0]  n_yc;
    logic [COLOR_W-1:0]       n_color;

    logic                     start;
    logic                     accept;
    logic                     emit_free;
    logic                     emit_load;
    t_snap                    snap;

    logic signed [WALK_W-1:0] b_x;
    logic signed [WALK_W-1:0] b_y;
    logic signed [DEC_W-1:0]  b_dec;
    logic signed [CHG_W-1:0]  b_xc;
    logic signed [CHG_W-1:0]  b_yc;
    logic signed [WALK_W-1:0] o_x;
    logic signed [WALK_W-1:0] o_y;
    logic signed [DEC_W-1:0]  o_dec;
    logic signed [DEC_W-1:0]  f_d1;
    logic signed [DEC_W+1:0]  f_test;
    logic [DEC_W-1:0]         rad_x2;

    assign start     = (i_in.op == OP_START);
    assign i_in.ready = emit_free;
    assign accept    = i_in.valid && i_in.ready;
    assign emit_load = accept && (start || r_busy);

    // iteration walk: start values or held state, then one midpoint step
    always_comb begin
        rad_x2  = {{(DEC_W-RAD_W-1){1'b0}}, i_in.radius, 1'b0};
        n_fill  = start ? i_in.filled : r_fill;
        n_cx    = start ? COORD_BITS'(i_in.center_x) : r_cx;
        n_cy    = start ? COORD_BITS'(i_in.center_y) : r_cy;
        n_color = start ? i_in.pixel_color : r_color;

        // base values of this iteration
        if (start && i_in.filled) begin
            b_x   = WALK_W'(i_in.radius);
            b_y   = '0;
            b_dec = '0;
            b_xc  = CHG_W'(1) - CHG_W'(rad_x2);
            b_yc  = '0;
        end else if (start) begin
            b_x   = '0;
            b_y   = WALK_W'(i_in.radius);
            b_dec = DEC_W'(3) - rad_x2;
            b_xc  = '0;
            b_yc  = '0;
        end else begin
            b_x   = r_x;
            b_y   = r_y;
            b_dec = r_dec;
            b_xc  = r_xc;
            b_yc  = r_yc;
        end

        // outline step, skipped on start
        o_x   = b_x;
        o_y   = b_y;
        o_dec = b_dec;
        if (!start) begin
            o_x = b_x + WALK_W'(1);
            if (b_dec > 0) begin
                o_y   = b_y - WALK_W'(1);
                o_dec = b_dec + ((DEC_W'(o_x) - DEC_W'(o_y)) <<< 2) + DEC_W'(10);
            end else begin
                o_dec = b_dec + (DEC_W'(o_x) <<< 2) + DEC_W'(6);
            end
        end

        // filled step, taken after the spans of the base values
        f_d1   = b_dec + DEC_W'(b_yc);
        f_test = ((DEC_W+2)'(f_d1) <<< 1) + (DEC_W+2)'(b_xc);

        snap.fill  = n_fill;
        snap.cx    = n_cx;
        snap.cy    = n_cy;
        snap.color = n_color;
        if (n_fill) begin
            n_y   = b_y + WALK_W'(1);
            n_yc  = b_yc + CHG_W'(2);
            if (f_test > 0) begin
                n_x   = b_x - WALK_W'(1);
                n_dec = f_d1 + DEC_W'(b_xc);
                n_xc  = b_xc + CHG_W'(2);
            end else begin
                n_x   = b_x;
                n_dec = f_d1;
                n_xc  = b_xc;
            end
            n_busy = (n_x >= n_y);
            snap.x = b_x;
            snap.y = b_y;
        end else begin
            n_x    = o_x;
            n_y    = o_y;
            n_dec  = o_dec;
            n_xc   = b_xc;
            n_yc   = b_yc;
            n_busy = (o_y >= o_x);
            snap.x = o_x;
            snap.y = o_y;
        end
        snap.last = !n_busy;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fill <= 1'b0;
        end else if (emit_load) begin
            r_busy <= n_busy;
            r_fill <= n_fill;
        end
    end

    // walk terms and held circle parameters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_dec   <= '0;
            r_xc    <= '0;
            r_yc    <= '0;
            r_color <= '0;
        end else if (emit_load) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_x     <= n_x;
            r_y     <= n_y;
            r_dec   <= n_dec;
            r_xc    <= n_xc;
            r_yc    <= n_yc;
            r_color <= n_color;
        end
    end

    mcr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .i_snap  (snap),
        .o_free  (emit_free),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // an idle step leaves the walk untouched
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !start && !r_busy) |=> (!r_busy && $stable(r_x) && $stable(r_y)))
        else $error("idle step changed walk state");

    // a start always produces an iteration
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && start) |-> emit_load)
        else $error("start word produced no spans");

    // a step on a running circle always produces an iteration
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !start && r_busy) |-> emit_load)
        else $error("step word on a running circle produced no spans");
`endif

endmodule

// ===== rtl/core/mcr_emit.sv =====
// ----------------------------------------------------------------------------
// mcr_emit: span emitter
// Holds one iteration snapshot and sends its spans through an output register
// one word per cycle unless stalled; eight pixels outline, four spans filled.
// ----------------------------------------------------------------------------
module mcr_emit
    import mcr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_snap  i_snap,
    output logic   o_free,
    mcr_out_if.source o_out
);

    t_snap              r_snap;
    logic               r_s_valid;
    logic [IDX_W-1:0]   r_idx;
    logic               r_o_valid;
    logic signed [SPAN_W-1:0] r_o_row;
    logic signed [SPAN_W-1:0] r_o_first;
    logic signed [SPAN_W-1:0] r_o_final;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_last;

    logic               out_free;
    logic               adv;
    logic               is_fin;
    logic               swap;
    logic               row_neg;
    logic signed [WALK_W-1:0] row_off;
    logic signed [WALK_W-1:0] col_off;
    logic signed [SPAN_W-1:0] cx_ext;
    logic signed [SPAN_W-1:0] cy_ext;
    logic signed [SPAN_W-1:0] row_ext;
    logic signed [SPAN_W-1:0] col_ext;
    logic signed [SPAN_W-1:0] n_row;
    logic signed [SPAN_W-1:0] c_plus;
    logic signed [SPAN_W-1:0] c_minus;
    logic signed [SPAN_W-1:0] n_first;
    logic signed [SPAN_W-1:0] n_final;

    // slot sequencing
    assign out_free = !r_o_valid || o_out.ready;
    assign adv      = r_s_valid && out_free;
    assign is_fin   = (r_idx == (r_snap.fill ? IDX_FILL_LAST : IDX_OUTLINE_LAST));
    assign o_free   = !r_s_valid || (adv && is_fin);

    // octant / span selection for the current slot
    always_comb begin
        swap    = r_snap.fill ? r_idx[1] : r_idx[2];
        row_neg = r_snap.fill ? r_idx[0] : r_idx[1];
        row_off = swap ? r_snap.x : r_snap.y;
        col_off = swap ? r_snap.y : r_snap.x;
        cx_ext  = SPAN_W'(r_snap.cx);
        cy_ext  = SPAN_W'(r_snap.cy);
        row_ext = SPAN_W'(row_off);
        col_ext = SPAN_W'(col_off);
        n_row   = row_neg ? (cy_ext - row_ext) : (cy_ext + row_ext);
        c_plus  = cx_ext + col_ext;
        c_minus = cx_ext - col_ext;
        if (r_snap.fill) begin
            n_first = c_minus;
            n_final = c_plus;
        end else begin
            n_first = r_idx[0] ? c_minus : c_plus;
            n_final = n_first;
        end
    end

    // snapshot holder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_idx     <= '0;
        end else if (i_load) begin
            r_s_valid <= 1'b1;
            r_idx     <= '0;
        end else if (adv && is_fin) begin
            r_s_valid <= 1'b0;
        end else if (adv) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_row   <= n_row;
            r_o_first <= n_first;
            r_o_final <= n_final;
            r_o_color <= r_snap.color;
            r_o_last  <= r_snap.last && is_fin;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.span_row   = r_o_row;
    assign o_out.span_first = r_o_first;
    assign o_out.span_final = r_o_final;
    assign o_out.span_color = r_o_color;
    assign o_out.last       = r_o_last;

`ifndef NO_ASSERTIONS
    // slot index stays inside the iteration
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> (r_idx <= (r_snap.fill ? IDX_FILL_LAST : IDX_OUTLINE_LAST)))
        else $error("emit slot index past iteration end");

    // a new snapshot never overwrites spans still pending
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_s_valid || (adv && is_fin)))
        else $error("snapshot loaded while spans pending");

    // emitter drains after its final slot without a reload
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_fin && !i_load) |=> !r_s_valid)
        else $error("emitter did not drain after final slot");

    // the circle end flag only rides on a final slot
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_fin) |=> !r_o_last)
        else $error("last flag on a non-final slot");

    // outline spans are single pixels
    a_outline_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_snap.fill) |=> (o_out.span_first == o_out.span_final))
        else $error("outline span wider than one pixel");
`endif

endmodule
